/* rtl/rsa_pkg.sv */
// shared constants and types for the rsa modular exponentiation block
`default_nettype none

package rsa_pkg;

	// width of the configuration registers and of the item fields
	localparam int FIELD_BITS = 32;
	localparam int WORD_BITS_DEFAULT = 32;
	localparam int CFG_INDEX_BITS = 2;

	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_MODULUS = 2'd0;
	localparam cfg_index_t REG_PUBLIC_EXP = 2'd1;
	localparam cfg_index_t REG_PRIVATE_EXP = 2'd2;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd14;
	localparam logic [FIELD_BITS-1:0] PUBLIC_EXP_RESET = 32'd5;
	localparam logic [FIELD_BITS-1:0] PRIVATE_EXP_RESET = 32'd11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

/* rtl/rsa_modexp_encrypt_decrypt.sv */
// top level of the rsa modular exponentiation block
`default_nettype none

// Textbook RSA transform: each item returns (value mod n) ^ e mod n for an encrypt
// command, or with exponent d for a decrypt command; a modulus below two gives 0.
// Items are worked one at a time by a bit-serial datapath. The value is reduced mod n
// one bit a cycle, then square-and-multiply walks all WORD_BITS exponent bits from the
// top; every modular multiply is a run of double-and-add steps with reduction, one
// multiplier bit a cycle. A modulus below two skips straight to the finish state. The
// finished result sits in an output register, so a new item may be accepted while it
// waits to be taken; a finished item waits in place while the previous result is still
// stalled. Configuration registers are to be written only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high and writes to an
// unknown index are dropped.
module rsa_modexp_encrypt_decrypt
	import rsa_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// item input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  command,
	input  wire logic [FIELD_BITS-1:0] value,
	// result output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [FIELD_BITS-1:0]      result,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [FIELD_BITS-1:0] cfg_data
);

	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);
	localparam int SUM_BITS = WORD_BITS + 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [SUM_BITS-1:0] sum_t;

	state_t state_q, state_d;

	logic [FIELD_BITS-1:0] modulus_q, public_exp_q, private_exp_q;
	logic out_valid_q;
	logic [FIELD_BITS-1:0] result_q;

	word_t n_q, exp_q, x_q, rem_q, base_q, mul_a_q, mul_b_q, prod_q;
	logic [CNT_BITS-1:0] cnt_q, ecnt_q;

	logic in_accept, out_free;
	logic step_last, exp_last, small_mod;
	word_t n_in, exp_in;

	// reduction step
	logic [WORD_BITS:0] rem_shift;
	word_t rem_next;

	// double-and-add step
	sum_t sum, n_ext, n2_ext;
	word_t prod_next;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign result = result_q;

	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign step_last = (cnt_q == CNT_LAST);
	assign exp_last = (ecnt_q == CNT_LAST);

	assign n_in = WORD_BITS'(modulus_q);
	assign exp_in = (command == CMD_DECRYPT) ? WORD_BITS'(private_exp_q)
		: WORD_BITS'(public_exp_q);
	assign small_mod = (n_in < WORD_BITS'(2));

	// restoring remainder, one value bit a cycle
	always_comb begin
		rem_shift = {rem_q, x_q[WORD_BITS-1]};
		if (rem_shift >= {1'b0, n_q})
			rem_next = WORD_BITS'(rem_shift - {1'b0, n_q});
		else
			rem_next = WORD_BITS'(rem_shift);
	end

	// prod = 2*prod + bit*a stays below 3n, so subtract n or 2n
	always_comb begin
		n_ext = {2'b00, n_q};
		n2_ext = {1'b0, n_q, 1'b0};
		sum = {1'b0, prod_q, 1'b0} + (mul_b_q[WORD_BITS-1] ? {2'b00, mul_a_q} : '0);
		if (sum >= n2_ext)
			prod_next = WORD_BITS'(sum - n2_ext);
		else if (sum >= n_ext)
			prod_next = WORD_BITS'(sum - n_ext);
		else
			prod_next = WORD_BITS'(sum);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept)
					state_d = small_mod ? ST_FINISH : ST_REDUCE;
			end
			ST_REDUCE: begin
				if (step_last)
					state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				if (step_last) begin
					if (exp_q[WORD_BITS-1])
						state_d = ST_MULT;
					else if (exp_last)
						state_d = ST_FINISH;
				end
			end
			ST_MULT: begin
				if (step_last)
					state_d = exp_last ? ST_FINISH : ST_SQUARE;
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			modulus_q <= MODULUS_RESET;
			public_exp_q <= PUBLIC_EXP_RESET;
			private_exp_q <= PRIVATE_EXP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODULUS: modulus_q <= cfg_data;
					REG_PUBLIC_EXP: public_exp_q <= cfg_data;
					REG_PRIVATE_EXP: private_exp_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= n_in;
				exp_q <= exp_in;
				x_q <= WORD_BITS'(value);
				rem_q <= '0;
				cnt_q <= '0;
				ecnt_q <= '0;
				prod_q <= '0;
			end
			ST_REDUCE: begin
				rem_q <= rem_next;
				x_q <= x_q << 1;
				if (step_last) begin
					cnt_q <= '0;
					base_q <= rem_next;
					// squaring the initial one
					mul_a_q <= WORD_BITS'(1);
					mul_b_q <= WORD_BITS'(1);
					prod_q <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_SQUARE, ST_MULT: begin
				if (step_last) begin
					cnt_q <= '0;
					mul_b_q <= prod_next;
					if (state_q == ST_SQUARE && exp_q[WORD_BITS-1]) begin
						mul_a_q <= base_q;
						prod_q <= '0;
					end else begin
						// next exponent bit starts with a square
						mul_a_q <= prod_next;
						exp_q <= exp_q << 1;
						ecnt_q <= ecnt_q + 1'b1;
						prod_q <= exp_last ? prod_next : '0;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					mul_b_q <= mul_b_q << 1;
					prod_q <= prod_next;
				end
			end
			ST_FINISH: begin
				if (out_free)
					result_q <= FIELD_BITS'(prod_q);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* dv/rsa_modexp_checker.sv */
// watches the item, result and register channels and checks each result against its prediction
`timescale 1ns / 1ps

module rsa_modexp_checker
	import rsa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic                  command,
	input  wire logic [FIELD_BITS-1:0] value,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [FIELD_BITS-1:0] result,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [FIELD_BITS-1:0] cfg_data,
	output int unsigned                mismatches,
	output int unsigned                outstanding
);

	typedef struct packed {
		logic                  cmd;
		logic [FIELD_BITS-1:0] word;
		logic [FIELD_BITS-1:0] residue;
	} rsa_expect_t;

	rsa_expect_t awaited[$];
	logic [FIELD_BITS-1:0] key_modulus = MODULUS_RESET;
	logic [FIELD_BITS-1:0] key_public = PUBLIC_EXP_RESET;
	logic [FIELD_BITS-1:0] key_private = PRIVATE_EXP_RESET;
	int unsigned fail_total = 0;

	// (base mod n) ^ exponent mod n, exact in 64 bits since every operand stays below n
	function automatic logic [FIELD_BITS-1:0] rsa_transform(
		input logic [FIELD_BITS-1:0] base,
		input logic [FIELD_BITS-1:0] exponent,
		input logic [FIELD_BITS-1:0] modulus
	);
		logic [63:0] acc;
		logic [63:0] b;
		logic [63:0] n;
		if (modulus < 2)
			return '0;
		n = 64'(modulus);
		b = 64'(base) % n;
		acc = 64'd1;
		for (int i = FIELD_BITS - 1; i >= 0; i--) begin
			acc = (acc * acc) % n;
			if (exponent[i])
				acc = (acc * b) % n;
		end
		return acc[FIELD_BITS-1:0];
	endfunction

	task automatic note_mismatch(input string msg);
		fail_total++;
		if (fail_total <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsa_expect_t head;
		rsa_expect_t fresh;
		if (!arst_n) begin
			key_modulus = MODULUS_RESET;
			key_public = PUBLIC_EXP_RESET;
			key_private = PRIVATE_EXP_RESET;
			awaited.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					note_mismatch($sformatf("result %h arrived with no item awaiting it", result));
				end else begin
					head = awaited.pop_front();
					if (result !== head.residue)
						note_mismatch($sformatf(
							"result mismatch: cmd %0d value %h expected %h got %h",
							head.cmd, head.word, head.residue, result));
				end
			end
			// prediction uses the keys in force before this edge
			if (in_valid && !in_stall) begin
				fresh.cmd = command;
				fresh.word = value;
				fresh.residue = rsa_transform(value,
					(command == CMD_DECRYPT) ? key_private : key_public, key_modulus);
				awaited.push_back(fresh);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS: key_modulus = cfg_data;
					REG_PUBLIC_EXP: key_public = cfg_data;
					REG_PRIVATE_EXP: key_private = cfg_data;
					default: ;
				endcase
			end
			outstanding <= awaited.size();
		end
		mismatches <= fail_total;
	end

endmodule

/* dv/rsa_modexp_encrypt_decrypt_tb.sv */
// stimulus and verdict for the rsa modular exponentiation block
`timescale 1ns / 1ps

module rsa_modexp_encrypt_decrypt_tb;
	import rsa_pkg::*;

	// index with no register behind it, writes must be dropped
	localparam cfg_index_t REG_UNUSED = 2'd3;
	localparam int unsigned ITEM_TARGET = 270;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [FIELD_BITS-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [FIELD_BITS-1:0] result;
	logic cfg_valid;
	logic cfg_ready;
	cfg_index_t cfg_index;
	logic [FIELD_BITS-1:0] cfg_data;

	int unsigned mismatches;
	int unsigned outstanding;

	// modulus currently loaded, only used to steer values near it
	logic [FIELD_BITS-1:0] key_n;
	int unsigned items_sent;
	logic sender_steady;

	always #10 clk = ~clk;

	rsa_modexp_encrypt_decrypt u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	rsa_modexp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (sender_steady || roll < 50)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 20);
		return $urandom_range(100, 2500);
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3, 4: return $urandom_range(2, 70000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 3);
			1: return key_n - 1;
			2: return key_n;
			3: return '1;
			4: return $urandom_range(0, key_n);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input logic cmd, input logic [FIELD_BITS-1:0] word);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= word;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [FIELD_BITS-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_MODULUS)
			key_n = data;
	endtask

	task automatic load_keys(input logic [FIELD_BITS-1:0] n, input logic [FIELD_BITS-1:0] e,
		input logic [FIELD_BITS-1:0] d);
		write_reg(REG_MODULUS, n);
		write_reg(REG_PUBLIC_EXP, e);
		write_reg(REG_PRIVATE_EXP, d);
		cfg_valid <= 1'b0;
	endtask

	// hold the sender until every awaited result has been taken
	task automatic drain();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(2000, 8000)) @(posedge clk);
			else
				repeat ($urandom_range(1, 60)) @(posedge clk);
			out_stall <= 1'b1;
			case ($urandom_range(0, 19))
				0: repeat ($urandom_range(200, 3000)) @(posedge clk);
				1, 2, 3, 4: repeat ($urandom_range(4, 30)) @(posedge clk);
				default: repeat ($urandom_range(1, 3)) @(posedge clk);
			endcase
			out_stall <= 1'b0;
		end
	end

	initial begin
		#200_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int unsigned phase_len;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_ENCRYPT;
		value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODULUS;
		cfg_data <= '0;
		key_n = MODULUS_RESET;
		items_sent = 0;
		sender_steady = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset keys, values around the modulus and the word extremes
		send_item(CMD_ENCRYPT, 32'd0);
		send_item(CMD_DECRYPT, 32'd0);
		send_item(CMD_ENCRYPT, 32'd1);
		send_item(CMD_DECRYPT, 32'd13);
		send_item(CMD_ENCRYPT, 32'd14);
		send_item(CMD_DECRYPT, 32'd15);
		send_item(CMD_ENCRYPT, '1);
		send_item(CMD_DECRYPT, '1);
		drain();

		// modulus zero, plus a write to the unused index
		write_reg(REG_MODULUS, 32'd0);
		write_reg(REG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
		send_item(CMD_ENCRYPT, 32'd5);
		send_item(CMD_DECRYPT, '1);
		drain();

		// modulus one
		write_reg(REG_MODULUS, 32'd1);
		cfg_valid <= 1'b0;
		send_item(CMD_ENCRYPT, 32'd7);
		send_item(CMD_DECRYPT, 32'd0);
		drain();

		// zero exponents give one, even for a zero value
		load_keys(32'd2, 32'd0, 32'd0);
		send_item(CMD_ENCRYPT, 32'd0);
		send_item(CMD_DECRYPT, 32'd1);
		send_item(CMD_ENCRYPT, '1);
		drain();

		// widest modulus and exponent
		load_keys('1, '1, 32'd1);
		send_item(CMD_ENCRYPT, '1);
		send_item(CMD_ENCRYPT, 32'hFFFF_FFFE);
		send_item(CMD_DECRYPT, 32'hFFFF_FFFE);
		send_item(CMD_DECRYPT, 32'h8000_0000);
		drain();

		// small textbook key pair, round trip
		load_keys(32'd3233, 32'd17, 32'd2753);
		send_item(CMD_ENCRYPT, 32'd65);
		send_item(CMD_DECRYPT, 32'd2790);
		drain();

		while (items_sent < ITEM_TARGET) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) != 0) begin
				case ($urandom_range(0, 19))
					0: write_reg(REG_MODULUS, $urandom_range(0, 1));
					1, 2: write_reg(REG_MODULUS, $urandom_range(2, 300));
					3: write_reg(REG_MODULUS, '1 - $urandom_range(0, 3));
					default: write_reg(REG_MODULUS, $urandom());
				endcase
			end
			if ($urandom_range(0, 5) != 0)
				write_reg(REG_PUBLIC_EXP, pick_exponent());
			if ($urandom_range(0, 5) != 0)
				write_reg(REG_PRIVATE_EXP, pick_exponent());
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_UNUSED, $urandom());
			cfg_valid <= 1'b0;

			phase_len = $urandom_range(12, 40);
			repeat (phase_len) begin
				send_item($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, pick_word());
				if ($urandom_range(0, 29) == 0)
					drain();
			end
			drain();
		end

		drain();
		repeat (2200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/rsa_pkg.sv
rtl/rsa_modexp_encrypt_decrypt.sv
dv/rsa_modexp_checker.sv
dv/rsa_modexp_encrypt_decrypt_tb.sv
